// File: src/daily_activity_summary_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the daily activity summary core
// Clocked property checks with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef DAILY_ACTIVITY_SUMMARY_CORE_DEFINES_SVH
`define DAILY_ACTIVITY_SUMMARY_CORE_DEFINES_SVH

// Check a property at every rising clock edge, suspended while reset is high.
`define DASC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define DASC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dasc_pkg.sv
// ----------------------------------------------------------------------------
// dasc_pkg
// Types, widths and constants shared by the daily activity summary core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dasc_pkg;

  // Day length in minute records and the width of the minute counter.
  localparam int MinuteW    = 11;
  localparam logic [MinuteW-1:0] MaxRecords = 11'd1440;

  // Accumulator widths.
  localparam int BigSumW    = 27;
  localparam int FloorSumW  = 19;
  localparam int HeartSumW  = 19;
  localparam int CountW     = 11;
  localparam int PeakW      = 16;
  localparam int RunSumW    = 14;
  localparam int AvgW       = 8;

  // The average divider retires one quotient bit per cycle.
  localparam int DivSteps   = HeartSumW;
  localparam int DivCountW  = 5;

  // Stream payload widths.
  localparam int InDataW    = 80;
  localparam int OutDataW   = 160;

  // Input record, lowest field in the lowest bits.
  typedef struct packed {
    logic [6:0]         pad;
    logic signed [3:0]  sleep_level;
    logic signed [16:0] step_count;
    logic signed [8:0]  heart_rate;
    logic signed [8:0]  floor_count;
    logic signed [16:0] distance_milli;
    logic signed [16:0] calories_milli;
  } in_item_t;

  // Daily summary, lowest field in the lowest bits.
  typedef struct packed {
    logic [MinuteW-1:0]   worst_end;
    logic [MinuteW-1:0]   worst_start;
    logic [RunSumW-1:0]   worst_sleep;
    logic [PeakW-1:0]     most_steps;
    logic [AvgW-1:0]      average_heart;
    logic [BigSumW-1:0]   total_steps;
    logic [FloorSumW-1:0] total_floors;
    logic [BigSumW-1:0]   total_distance;
    logic [BigSumW-1:0]   total_calories;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIVIDE,
    ST_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } dp_status_t;

endpackage

// File: src/dasc_div.sv
// ----------------------------------------------------------------------------
// dasc_div
// Restoring divider that forms one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dasc_div
  import dasc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [HeartSumW-1:0] dividend,
  input  logic [CountW-1:0]    divisor,
  output logic                 busy,
  output logic [HeartSumW-1:0] quotient
);

  logic [CountW-1:0]    rem;
  logic [HeartSumW-1:0] quo;
  logic [DivCountW-1:0] steps_left;
  logic [CountW:0]      rem_shift;
  logic [CountW+1:0]    diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_shift = {rem, quo[HeartSumW-1]};
    diff      = {1'b0, rem_shift} - {2'b00, divisor};
    fits      = ~diff[CountW+1];
  end

  // Step counter is control state; the working registers need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (start) begin
      steps_left <= DivCountW'(DivSteps);
    end else if (steps_left != '0) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (steps_left != '0) begin
      rem <= fits ? diff[CountW-1:0] : rem_shift[CountW-1:0];
      quo <= {quo[HeartSumW-2:0], fits};
    end
  end

  assign busy     = (steps_left != '0);
  assign quotient = quo;

endmodule

// File: src/dasc_datapath.sv
// ----------------------------------------------------------------------------
// dasc_datapath
// Daily accumulators, bad-sleep run tracking, average divider and the
// summary output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dasc_datapath
  import dasc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  in_item_t   item,
  output out_item_t  summary
);

  logic [BigSumW-1:0]   calorie_sum, distance_sum, step_sum;
  logic [FloorSumW-1:0] floor_sum;
  logic [HeartSumW-1:0] heart_sum;
  logic [CountW-1:0]    heart_valid_count;
  logic [PeakW-1:0]     step_peak;
  logic [MinuteW-1:0]   minute_index;
  logic                 run_active;
  logic [RunSumW-1:0]   run_total;
  logic [MinuteW-1:0]   run_begin;
  logic [RunSumW-1:0]   best_total;
  logic [MinuteW-1:0]   best_begin, best_finish;

  logic [BigSumW-1:0]   calorie_sum_next, distance_sum_next, step_sum_next;
  logic [FloorSumW-1:0] floor_sum_next;
  logic [HeartSumW-1:0] heart_sum_next;
  logic [CountW-1:0]    heart_valid_count_next;
  logic [PeakW-1:0]     step_peak_next;
  logic                 run_active_next;
  logic [RunSumW-1:0]   run_total_next;
  logic [MinuteW-1:0]   run_begin_next;
  logic [RunSumW-1:0]   best_total_next;
  logic [MinuteW-1:0]   best_begin_next, best_finish_next;

  logic [BigSumW:0]     cal_add, dist_add, step_add;
  logic [FloorSumW:0]   floor_add;
  logic [HeartSumW:0]   heart_add;
  logic [CountW:0]      count_add;
  logic [RunSumW:0]     run_add;
  logic [RunSumW-1:0]   run_base;
  logic                 sleep_bad;
  logic                 day_open;

  logic [RunSumW-1:0]   fin_total;
  logic [MinuteW-1:0]   fin_begin, fin_finish;
  logic [AvgW-1:0]      avg;
  logic                 div_busy;
  logic [HeartSumW-1:0] quotient;

  // Serial divider for the heart-rate average.
  dasc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (heart_sum),
    .divisor  (heart_valid_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status.div_busy = div_busy;

  // Saturating sums; a negative field is missing and adds nothing.
  always_comb begin
    day_open  = (minute_index < MaxRecords);
    cal_add   = {1'b0, calorie_sum} + (BigSumW+1)'(item.calories_milli[15:0]);
    dist_add  = {1'b0, distance_sum} + (BigSumW+1)'(item.distance_milli[15:0]);
    step_add  = {1'b0, step_sum} + (BigSumW+1)'(item.step_count[15:0]);
    floor_add = {1'b0, floor_sum} + (FloorSumW+1)'(item.floor_count[7:0]);
    heart_add = {1'b0, heart_sum} + (HeartSumW+1)'(item.heart_rate[7:0]);
    count_add = {1'b0, heart_valid_count} + (CountW+1)'(1);

    calorie_sum_next = calorie_sum;
    if (!item.calories_milli[16]) begin
      calorie_sum_next = cal_add[BigSumW] ? '1 : cal_add[BigSumW-1:0];
    end
    distance_sum_next = distance_sum;
    if (!item.distance_milli[16]) begin
      distance_sum_next = dist_add[BigSumW] ? '1 : dist_add[BigSumW-1:0];
    end
    floor_sum_next = floor_sum;
    if (!item.floor_count[8]) begin
      floor_sum_next = floor_add[FloorSumW] ? '1 : floor_add[FloorSumW-1:0];
    end
    step_sum_next  = step_sum;
    step_peak_next = step_peak;
    if (!item.step_count[16]) begin
      step_sum_next = step_add[BigSumW] ? '1 : step_add[BigSumW-1:0];
      if (item.step_count[15:0] > step_peak) begin
        step_peak_next = item.step_count[15:0];
      end
    end
    heart_sum_next         = heart_sum;
    heart_valid_count_next = heart_valid_count;
    if (!item.heart_rate[8]) begin
      heart_sum_next = heart_add[HeartSumW] ? '1 : heart_add[HeartSumW-1:0];
      heart_valid_count_next = count_add[CountW] ? '1 : count_add[CountW-1:0];
    end
  end

  // Bad-sleep run: levels above one extend the run, anything else closes it.
  always_comb begin
    sleep_bad = ~item.sleep_level[3] && (item.sleep_level[2:0] > 3'd1);
    run_base  = run_active ? run_total : '0;
    run_add   = {1'b0, run_base} + (RunSumW+1)'(item.sleep_level[2:0]);

    run_active_next  = run_active;
    run_total_next   = run_total;
    run_begin_next   = run_begin;
    best_total_next  = best_total;
    best_begin_next  = best_begin;
    best_finish_next = best_finish;
    if (sleep_bad) begin
      run_active_next = 1'b1;
      if (!run_active) begin
        run_begin_next = minute_index;
      end
      run_total_next = run_add[RunSumW] ? '1 : run_add[RunSumW-1:0];
    end else begin
      if (run_active && (run_total > best_total)) begin
        best_total_next  = run_total;
        best_begin_next  = run_begin;
        best_finish_next = minute_index;
      end
      run_active_next = 1'b0;
      run_total_next  = '0;
    end
  end

  // A run still open at the end of the day closes at the current minute.
  always_comb begin
    fin_total  = best_total;
    fin_begin  = best_begin;
    fin_finish = best_finish;
    if (run_active && (run_total > best_total)) begin
      fin_total  = run_total;
      fin_begin  = run_begin;
      fin_finish = minute_index;
    end
    if (heart_valid_count == '0) begin
      avg = '0;
    end else if (quotient > HeartSumW'(255)) begin
      avg = '1;
    end else begin
      avg = quotient[AvgW-1:0];
    end
  end

  // Day state: accumulate open-day transfers, clear as the summary loads.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      calorie_sum       <= '0;
      distance_sum      <= '0;
      floor_sum         <= '0;
      step_sum          <= '0;
      heart_sum         <= '0;
      heart_valid_count <= '0;
      step_peak         <= '0;
      minute_index      <= '0;
      run_active        <= 1'b0;
      run_total         <= '0;
      run_begin         <= '0;
      best_total        <= '0;
      best_begin        <= '0;
      best_finish       <= '0;
    end else if (cmd.accum && day_open) begin
      calorie_sum       <= calorie_sum_next;
      distance_sum      <= distance_sum_next;
      floor_sum         <= floor_sum_next;
      step_sum          <= step_sum_next;
      heart_sum         <= heart_sum_next;
      heart_valid_count <= heart_valid_count_next;
      step_peak         <= step_peak_next;
      minute_index      <= minute_index + 1'b1;
      run_active        <= run_active_next;
      run_total         <= run_total_next;
      run_begin         <= run_begin_next;
      best_total        <= best_total_next;
      best_begin        <= best_begin_next;
      best_finish       <= best_finish_next;
    end
  end

  // Summary output register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      summary.total_calories <= calorie_sum;
      summary.total_distance <= distance_sum;
      summary.total_floors   <= floor_sum;
      summary.total_steps    <= step_sum;
      summary.average_heart  <= avg;
      summary.most_steps     <= step_peak;
      summary.worst_sleep    <= fin_total;
      summary.worst_start    <= fin_begin;
      summary.worst_end      <= fin_finish;
    end
  end

endmodule

// File: src/dasc_ctrl.sv
// ----------------------------------------------------------------------------
// dasc_ctrl
// Sequencer for record transfers, the average divide and summary hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dasc_ctrl
  import dasc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state, state_next;
  logic        out_valid, out_valid_next;
  logic        out_free;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    out_free       = ~out_valid | m_tready;
    state_next     = state;
    cmd            = '0;
    s_tready       = 1'b0;
    out_valid_next = out_valid & ~m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accum = 1'b1;
          if (s_tlast) begin
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!status.div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

// File: src/daily_activity_summary_core.sv
// ----------------------------------------------------------------------------
// daily_activity_summary_core
// Per-minute activity records in, one daily summary out on the last record.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                          Marker
//  s_*      in         one minute record (s_tdata)      s_tlast = last record
//  m_*      out        daily summary (m_tdata)          none
//
//  A record without s_tlast leaves s_tready high.
//  A record with s_tlast then holds s_tready low while the controller launches
//  the heart-rate divide, waits out the 19 divider steps and sees them done,
//  then loads the summary register and clears the day state.
//  Synchronous reset clears the day state and the output valid flag.
//  Records are taken while a summary waits on m_tready; the next load waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module daily_activity_summary_core
  import dasc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // Fields from bit 0: calories_milli, distance_milli, floor_count,
  // heart_rate, step_count, sleep_level, then zero padding.
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  // Fields from bit 0: total_calories, total_distance, total_floors,
  // total_steps, average_heart, most_steps, worst_sleep, worst_start,
  // worst_end.
  output logic [OutDataW-1:0] m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   item;
  out_item_t  summary;

  assign item    = in_item_t'(s_tdata);
  assign m_tdata = OutDataW'(summary);

  // Controller.
  dasc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath.
  dasc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .item    (item),
    .summary (summary)
  );

endmodule

// File: src/dasc_checker.sv
// ----------------------------------------------------------------------------
// dasc_checker
// Port-level checks for the daily activity summary core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "daily_activity_summary_core_defines.svh"

module dasc_checker
  import dasc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tlast,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  out_item_t summary;

  assign summary = out_item_t'(m_tdata);

  // A stalled summary stays offered and unchanged.
  `DASC_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "summary dropped or changed while stalled")

  // An ordinary record never stalls the input side.
  `DASC_ASSERT(a_plain_no_stall, clk, rst, s_tvalid && s_tready && !s_tlast |=> s_tready, "input stalled after a plain record")

  // The last record of a day holds off input while the summary is built.
  `DASC_ASSERT(a_last_blocks, clk, rst, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken during summary build")

  // The worst run never ends before it starts.
  `DASC_ASSERT(a_run_order, clk, rst, m_tvalid |-> summary.worst_end >= summary.worst_start, "worst run ends before its start")

endmodule

bind daily_activity_summary_core dasc_checker u_dasc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
